### design/c3rb_pkg.sv
package c3rb_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_KTOP   = 3'd2;
    localparam logic [2:0] REG_KMID   = 3'd3;
    localparam logic [2:0] REG_KBOT   = 3'd4;
    localparam logic [2:0] REG_RECIP  = 3'd5;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } pix_in_t;

    typedef struct packed {
        logic [15:0] out_row;
        logic [9:0]  out_col;
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic        run_last;
    } pix_out_t;

    typedef struct packed {
        logic [15:0] row;
        logic [12:0] col;
        logic [15:0] h;
        logic [13:0] w;
        logic        last;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_MUL,
        BK_SUM,
        BK_FIN,
        BK_OUT
    } bk_state_t;

    function automatic logic [7:0] finish(input logic signed [27:0] acc,
                                          input logic [23:0] rcp);
        logic signed [52:0] p;
        logic [52:0] v;
        begin
            p = acc * $signed({1'b0, rcp});
            v = 53'(p) + 53'(1 << 23);
            if (p <= 0)
                finish = 8'd0;
            else if (v[52:24] > 29'd255)
                finish = 8'd255;
            else
                finish = v[31:24];
        end
    endfunction

    // base-4 digit sums keep the value modulo 3
    function automatic logic [1:0] mod3_16(input logic [15:0] x);
        logic [4:0] s;
        logic [2:0] t;
        logic [2:0] u;
        begin
            s = '0;
            for (int i = 0; i < 8; i++)
                s = s + 5'(x[2*i +: 2]);
            t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
            u = 3'(t[1:0]) + 3'(t[2]);
            if (u == 3'd3)
                mod3_16 = 2'd0;
            else if (u == 3'd4)
                mod3_16 = 2'd1;
            else
                mod3_16 = u[1:0];
        end
    endfunction

    function automatic logic [1:0] tap_row(input logic [3:0] t);
        begin
            if (t < 4'd3)
                tap_row = 2'd0;
            else if (t < 4'd6)
                tap_row = 2'd1;
            else
                tap_row = 2'd2;
        end
    endfunction

    function automatic logic [1:0] tap_col(input logic [3:0] t);
        begin
            if (t < 4'd3)
                tap_col = t[1:0];
            else if (t < 4'd6)
                tap_col = 2'(t - 4'd3);
            else
                tap_col = 2'(t - 4'd6);
        end
    endfunction

endpackage

### design/c3rb_front.sv
module c3rb_front
    import c3rb_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int CW = $clog2(MAX_WIDTH) + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pix_in_t       in_data,
    input  logic [10:0]   frame_width,
    input  logic [15:0]   frame_height,
    output logic          wr_en,
    output logic [1:0]    wr_bank,
    output logic [CW-2:0] wr_col,
    output logic [23:0]   wr_data,
    output logic          job_push,
    output job_t          job,
    input  logic          q_space,
    input  logic          store_busy
);
    logic [15:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [1:0] bank_reg, bank_next;
    logic [2:0] sub_reg, sub_next;
    logic busy_reg, busy_next;
    logic [CW-1:0] w;
    logic [15:0] h, r;
    logic [CW-1:0] c;
    logic [1:0] rb;
    logic [2:0] n;
    logic [15:0] jr [4];
    logic [CW-1:0] jc [4];

    always_comb
    begin
        if (frame_width < 11'd2)
            w = CW'(2);
        else if ({3'd0, frame_width} > 14'(MAX_WIDTH))
            w = CW'(MAX_WIDTH);
        else
            w = CW'(frame_width);
        h = (frame_height < 16'd2) ? 16'd2 : frame_height;
        c = (col_reg > w - 1'b1) ? w - 1'b1 : col_reg;
        r = (row_reg > h - 1'b1) ? h - 1'b1 : row_reg;
        rb = (r == row_reg) ? bank_reg : mod3_16(r);
        n = 3'd0;
        for (int i = 0; i < 4; i++)
        begin
            jr[i] = '0;
            jc[i] = '0;
        end
        if (r >= 16'd1 && c >= CW'(1))
        begin
            jr[n[1:0]] = r - 1'b1;
            jc[n[1:0]] = c - 1'b1;
            n = n + 3'd1;
            if (c == w - 1'b1)
            begin
                jr[n[1:0]] = r - 1'b1;
                jc[n[1:0]] = w - 1'b1;
                n = n + 3'd1;
            end
        end
        if (r == h - 1'b1 && c >= CW'(1))
        begin
            jr[n[1:0]] = r;
            jc[n[1:0]] = c - 1'b1;
            n = n + 3'd1;
            if (c == w - 1'b1)
            begin
                jr[n[1:0]] = r;
                jc[n[1:0]] = w - 1'b1;
                n = n + 3'd1;
            end
        end
    end

    // hold new pixels while jobs are still being pushed or queued results still have taps to read
    assign in_ready = !busy_reg && !store_busy;
    assign wr_en = in_valid && in_ready;
    assign wr_bank = rb;
    assign wr_col = c[CW-2:0];
    assign wr_data = {in_data.in_blue, in_data.in_green, in_data.in_red};

    logic [2:0] tot_reg, tot_next;
    logic [15:0] jr_s [4];
    logic [CW-1:0] jc_s [4];
    logic [15:0] h_reg;
    logic [CW-1:0] w_reg;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        sub_next = sub_reg;
        tot_next = tot_reg;
        job_push = 1'b0;
        job.row = jr_s[sub_reg[1:0]];
        job.col = 13'(jc_s[sub_reg[1:0]]);
        job.h = h_reg;
        job.w = 14'(w_reg);
        job.last = (sub_reg + 3'd1 == tot_reg);
        if (busy_reg)
        begin
            if (q_space)
            begin
                job_push = 1'b1;
                sub_next = sub_reg + 3'd1;
                if (sub_reg + 3'd1 == tot_reg)
                    busy_next = 1'b0;
            end
        end
        else if (wr_en)
        begin
            if (c + 1'b1 >= w)
            begin
                col_next = '0;
                if (r + 16'd1 >= h)
                begin
                    row_next = '0;
                    bank_next = 2'd0;
                end
                else
                begin
                    row_next = r + 16'd1;
                    bank_next = (rb == 2'd2) ? 2'd0 : rb + 2'd1;
                end
            end
            else
            begin
                col_next = c + 1'b1;
                row_next = r;
                bank_next = rb;
            end
            if (n != 3'd0)
            begin
                busy_next = 1'b1;
                sub_next = 3'd0;
                tot_next = n;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !busy_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                jr_s[i] <= jr[i];
                jc_s[i] <= jc[i];
            end
            h_reg <= h;
            w_reg <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            bank_reg <= '0;
            busy_reg <= 1'b0;
            sub_reg <= '0;
            tot_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
            sub_reg <= sub_next;
            tot_reg <= tot_next;
        end
    end
endmodule

### design/c3rb_queue.sv
module c3rb_queue
    import c3rb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic space,
    input  logic pop,
    output logic nonempty,
    output job_t pop_data
);
    job_t mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign space = cnt_reg != 3'd4;
    assign nonempty = cnt_reg != 3'd0;
    assign pop_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 2'd1;
            if (pop)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end
endmodule

### design/c3rb_back.sv
module c3rb_back
    import c3rb_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int CW = $clog2(MAX_WIDTH) + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [1:0]    wr_bank,
    input  logic [CW-2:0] wr_col,
    input  logic [23:0]   wr_data,
    input  logic          q_nonempty,
    input  job_t          q_data,
    output logic          q_pop,
    output logic          rd_busy,
    input  logic [47:0]   k_top,
    input  logic [47:0]   k_mid,
    input  logic [47:0]   k_bot,
    input  logic [23:0]   rcp,
    output logic          out_valid,
    input  logic          out_ready,
    output pix_out_t      out_data
);
    localparam int AW = $clog2(3 * MAX_WIDTH);

    logic [23:0] mem [3 * MAX_WIDTH];
    logic [23:0] rd_reg;
    bk_state_t st_reg, st_next;
    logic [3:0] tap_reg, tap_next;
    logic [3:0] rtap_reg;
    logic rv_reg;
    logic mv_reg;
    job_t job_reg;
    logic signed [27:0] acc_reg [3];
    logic signed [26:0] prod_reg [3];
    logic pv_reg;
    pix_out_t res_reg;
    logic ov_reg;

    logic [1:0] k, l;
    logic signed [17:0] rr, cc;
    logic [15:0] rm;
    logic [CW-1:0] cm;
    logic [1:0] bank;
    logic [AW-1:0] ra;
    logic [47:0] krow;
    logic signed [15:0] coef;

    always_comb
    begin
        k = tap_row(tap_reg);
        l = tap_col(tap_reg);
        rr = $signed({2'b0, job_reg.row}) + $signed({16'd0, k}) - 18'sd1;
        cc = $signed({5'b0, job_reg.col}) + $signed({16'd0, l}) - 18'sd1;
        if (rr < 0)
            rm = 16'd1;
        else if (rr >= $signed({2'b0, job_reg.h}))
            rm = job_reg.h - 16'd2;
        else
            rm = rr[15:0];
        if (cc < 0)
            cm = CW'(1);
        else if (cc >= $signed({4'b0, job_reg.w}))
            cm = CW'(job_reg.w - 14'd2);
        else
            cm = CW'(cc);
        bank = mod3_16(rm);
        ra = AW'(bank) * AW'(MAX_WIDTH) + AW'(cm[CW-2:0]);
        case (tap_row(rtap_reg))
            2'd0: krow = k_top;
            2'd1: krow = k_mid;
            default: krow = k_bot;
        endcase
        case (tap_col(rtap_reg))
            2'd0: coef = krow[15:0];
            2'd1: coef = krow[31:16];
            default: coef = krow[47:32];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(wr_bank) * AW'(MAX_WIDTH) + AW'(wr_col)] <= wr_data;
        rd_reg <= mem[ra];
    end

    assign rd_busy = (st_reg == BK_READ);

    always_comb
    begin
        st_next = st_reg;
        tap_next = tap_reg;
        q_pop = 1'b0;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (q_nonempty && !ov_reg)
                begin
                    q_pop = 1'b1;
                    st_next = BK_READ;
                    tap_next = '0;
                end
            end
            BK_READ:
            begin
                if (tap_reg == 4'd8)
                    st_next = BK_MUL;
                else
                    tap_next = tap_reg + 4'd1;
            end
            BK_MUL: if (!rv_reg && !pv_reg) st_next = BK_FIN;
            BK_SUM: st_next = BK_FIN;
            BK_FIN: st_next = BK_OUT;
            BK_OUT: st_next = BK_IDLE;
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == BK_IDLE && q_pop)
        begin
            job_reg <= q_data;
            for (int i = 0; i < 3; i++)
                acc_reg[i] <= '0;
        end
        rtap_reg <= tap_reg;
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i] <= 27'(coef * $signed({1'b0, rd_reg[8*i +: 8]}));
            if (mv_reg)
                acc_reg[i] <= acc_reg[i] + 28'(prod_reg[i]);
        end
        if (st_reg == BK_FIN)
        begin
            res_reg.out_row <= job_reg.row;
            res_reg.out_col <= job_reg.col[9:0];
            res_reg.out_red <= finish(acc_reg[0], rcp);
            res_reg.out_green <= finish(acc_reg[1], rcp);
            res_reg.out_blue <= finish(acc_reg[2], rcp);
            res_reg.run_last <= job_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_IDLE;
            tap_reg <= '0;
            rv_reg <= 1'b0;
            mv_reg <= 1'b0;
            pv_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            tap_reg <= tap_next;
            rv_reg <= (st_reg == BK_READ);
            mv_reg <= rv_reg;
            pv_reg <= mv_reg;
            if (st_reg == BK_OUT)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign out_data = res_reg;
endmodule

### design/conv3x3_reflect_border.sv
// 3x3 RGB convolution with reflect-101 borders.
// Input channel in_valid/in_ready carries one raster pixel per item.
// Output channel out_valid/out_ready carries filtered pixels tagged with
// row and column; run_last marks the last result caused by one input.
// An input gives zero to four results; row ends and the last row give runs.
// Config channel cfg_valid/cfg_ready writes register cfg_index with cfg_data;
// write only while idle.
// The front takes a pixel per cycle while it causes no result and no queued
// result still reads the line store; a pixel with results holds in_ready low
// while they enter a four-entry queue and until the back has read their taps.
// The back reads nine taps from the line store, one per cycle, multiplies
// and accumulates them; it registers the result and takes the next queued
// result only once the last one has been accepted on the output.
// Reset clears counters to row 0, column 0 and loads the identity kernel.
// Line store contents are undefined until written.
// A stalled receiver holds the result register; the back then holds the
// queue, and the front stops taking pixels once a result waits in it.
module conv3x3_reflect_border
    import c3rb_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pix_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output pix_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    localparam int CW = $clog2(MAX_WIDTH) + 1;

    logic [10:0] fw_reg;
    logic [15:0] fh_reg;
    logic [47:0] kt_reg, km_reg, kb_reg;
    logic [23:0] rc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 11'd1024;
            fh_reg <= 16'd1024;
            kt_reg <= '0;
            km_reg <= 48'd16777216;
            kb_reg <= '0;
            rc_reg <= 24'd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH:  fw_reg <= cfg_data[10:0];
                REG_HEIGHT: fh_reg <= cfg_data[15:0];
                REG_KTOP:   kt_reg <= cfg_data;
                REG_KMID:   km_reg <= cfg_data;
                REG_KBOT:   kb_reg <= cfg_data;
                REG_RECIP:  rc_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    logic wr_en, job_push, q_space, q_pop, q_nonempty;
    logic rd_busy, store_busy;
    logic [1:0] wr_bank;
    logic [CW-2:0] wr_col;
    logic [23:0] wr_data;
    job_t job, q_data;
    logic in_rdy_f;

    assign in_ready = in_rdy_f;
    assign store_busy = q_nonempty || rd_busy;

    c3rb_front #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_rdy_f),
        .in_data(in_data), .frame_width(fw_reg), .frame_height(fh_reg),
        .wr_en(wr_en), .wr_bank(wr_bank), .wr_col(wr_col), .wr_data(wr_data),
        .job_push(job_push), .job(job), .q_space(q_space),
        .store_busy(store_busy)
    );

    c3rb_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(job_push), .push_data(job),
        .space(q_space), .pop(q_pop), .nonempty(q_nonempty), .pop_data(q_data)
    );

    c3rb_back #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_back (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_bank(wr_bank),
        .wr_col(wr_col), .wr_data(wr_data), .q_nonempty(q_nonempty),
        .q_data(q_data), .q_pop(q_pop), .rd_busy(rd_busy), .k_top(kt_reg),
        .k_mid(km_reg), .k_bot(kb_reg), .rcp(rc_reg), .out_valid(out_valid),
        .out_ready(out_ready), .out_data(out_data)
    );
endmodule
